FILE: src/slm_pkg.sv
// Shared types and command codes for the sorted list merge block.
`default_nettype none

package slm_pkg;

    localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] CMD_MERGE      = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] merged_value;
        logic               from_left;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic load_left;
        logic load_right;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic lists_empty;
        logic step_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/slm_datapath.sv
// Datapath of the merge block: list stores, counts, read pointers and result register.
`default_nettype none

module slm_datapath #(
    parameter int LIST_DEPTH    = 32,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [15:0] load_value,
    input  wire slm_pkg::ctrl_cmd_t cmd,
    output slm_pkg::dp_status_t     status,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output slm_pkg::out_item_t      result
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

    logic [ELEMENT_WIDTH-1:0] left_mem_reg  [LIST_DEPTH];
    logic [ELEMENT_WIDTH-1:0] right_mem_reg [LIST_DEPTH];

    logic [CNT_W-1:0] left_count_reg, left_count_next;
    logic [CNT_W-1:0] right_count_reg, right_count_next;
    logic [CNT_W-1:0] left_ptr_reg, left_ptr_next;
    logic [CNT_W-1:0] right_ptr_reg, right_ptr_next;

    logic               result_valid_reg, result_valid_next;
    slm_pkg::out_item_t result_reg, result_next;

    logic [ELEMENT_WIDTH-1:0] elem_in;
    logic [ELEMENT_WIDTH-1:0] left_head;
    logic [ELEMENT_WIDTH-1:0] right_head;
    logic [ELEMENT_WIDTH-1:0] chosen;
    logic                     left_done;
    logic                     right_done;
    logic                     take_left;
    logic [CNT_W:0]           total;
    logic [CNT_W:0]           emitted;

    assign elem_in    = ELEMENT_WIDTH'($signed(load_value));
    assign left_head  = left_mem_reg[left_ptr_reg[IDX_W-1:0]];
    assign right_head = right_mem_reg[right_ptr_reg[IDX_W-1:0]];
    assign left_done  = (left_ptr_reg == left_count_reg);
    assign right_done = (right_ptr_reg == right_count_reg);
    assign take_left  = !left_done && (right_done || ($signed(left_head) <= $signed(right_head)));
    assign chosen     = take_left ? left_head : right_head;

    assign total   = {1'b0, left_count_reg} + {1'b0, right_count_reg};
    assign emitted = {1'b0, left_ptr_reg} + {1'b0, right_ptr_reg} + (CNT_W + 1)'(1);

    assign status.lists_empty = (total == '0);
    assign status.step_last   = (emitted == total);
    assign status.out_free    = !result_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_left && (left_count_reg != FULL_COUNT))
        begin
            left_mem_reg[left_count_reg[IDX_W-1:0]] <= elem_in;
        end
        if (cmd.load_right && (right_count_reg != FULL_COUNT))
        begin
            right_mem_reg[right_count_reg[IDX_W-1:0]] <= elem_in;
        end
    end

    always_comb
    begin
        left_count_next   = left_count_reg;
        right_count_next  = right_count_reg;
        left_ptr_next     = left_ptr_reg;
        right_ptr_next    = right_ptr_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (cmd.load_left && (left_count_reg != FULL_COUNT))
        begin
            left_count_next = left_count_reg + CNT_W'(1);
        end
        if (cmd.load_right && (right_count_reg != FULL_COUNT))
        begin
            right_count_next = right_count_reg + CNT_W'(1);
        end
        if (cmd.step)
        begin
            result_valid_next        = 1'b1;
            result_next.merged_value = 16'(chosen);
            result_next.from_left    = take_left;
            result_next.last         = status.step_last;
            if (take_left)
            begin
                left_ptr_next = left_ptr_reg + CNT_W'(1);
            end
            else
            begin
                right_ptr_next = right_ptr_reg + CNT_W'(1);
            end
            if (status.step_last)
            begin
                left_count_next  = '0;
                right_count_next = '0;
                left_ptr_next    = '0;
                right_ptr_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg   <= '0;
            right_count_reg  <= '0;
            left_ptr_reg     <= '0;
            right_ptr_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            left_count_reg   <= left_count_next;
            right_count_reg  <= right_count_next;
            left_ptr_reg     <= left_ptr_next;
            right_ptr_reg    <= right_ptr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_left_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_ptr_reg <= left_count_reg)
        else $error("left read pointer passed the left count");

    a_right_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        right_ptr_reg <= right_count_reg)
        else $error("right read pointer passed the right count");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.step_last |=> status.lists_empty && result_valid_reg && result_reg.last)
        else $error("lists not cleared or last flag missing after the final step");

    a_no_step_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !status.lists_empty && status.out_free)
        else $error("merge step issued with empty lists or a blocked result register");

endmodule

`default_nettype wire

FILE: src/slm_controller.sv
// Controller state machine that sequences loads and merge runs.
`default_nettype none

module slm_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire logic [1:0]          command,
    input  wire slm_pkg::dp_status_t status,
    output slm_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_MERGE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign item_ready     = (state_reg == S_IDLE);
    assign accept         = item_valid && item_ready;
    assign cmd.load_left  = accept && (command == slm_pkg::CMD_LOAD_LEFT);
    assign cmd.load_right = accept && (command == slm_pkg::CMD_LOAD_RIGHT);
    assign cmd.step       = (state_reg == S_MERGE) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == slm_pkg::CMD_MERGE) && !status.lists_empty)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                if (cmd.step && status.step_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sorted_list_merge.sv
// Top level of the two-way merge of sorted lists.
// A load gives no result; loads can be accepted back to back.
// A merge of N stored values gives its first result after the merge transfer, through the
// state register and the result register, and then one result per cycle while result_ready is high.
// item_ready is low while a merge run is in progress, so no new item is taken until the run ends.
// Reset clears the counts, pointers and result valid; the list stores are not cleared.
`default_nettype none

module sorted_list_merge #(
    parameter int LIST_DEPTH    = 32,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire slm_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output slm_pkg::out_item_t      result
);

    slm_pkg::ctrl_cmd_t  cmd;
    slm_pkg::dp_status_t status;

    slm_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (item.command),
        .status     (status),
        .cmd        (cmd)
    );

    slm_datapath #(
        .LIST_DEPTH    (LIST_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_value   (item.value),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: dv/sorted_list_merge_checker.sv
// Checker that predicts merged runs from observed transfers and compares the results.
`timescale 1ns / 1ps

module sorted_list_merge_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_ready,
    input  wire slm_pkg::in_item_t  item,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire slm_pkg::out_item_t result,
    output int                      error_count,
    output int                      outstanding
);

    localparam int DEPTH = 32;

    logic signed [15:0] left_list [DEPTH];
    logic signed [15:0] right_list [DEPTH];
    int                 left_fill = 0;
    int                 right_fill = 0;
    slm_pkg::out_item_t merged_run_q [$];
    slm_pkg::out_item_t expected;
    int                 lp;
    int                 rp;
    int                 total;
    logic               take_left;

    initial
    begin
        error_count = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_fill = 0;
            right_fill = 0;
            merged_run_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // Results are checked before the input transfer of the same edge is absorbed,
            // since a merge accepted now cannot have produced a result yet.
            if (result_valid && result_ready)
            begin
                if (merged_run_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, got value %0d from_left %0b last %0b",
                             $time, result.merged_value, result.from_left, result.last);
                end
                else
                begin
                    expected = merged_run_q.pop_front();
                    if (result.merged_value !== expected.merged_value ||
                        result.from_left !== expected.from_left ||
                        result.last !== expected.last)
                    begin
                        error_count++;
                        $display("%0t: mismatch, expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 $time, expected.merged_value, expected.from_left,
                                 expected.last, result.merged_value, result.from_left,
                                 result.last);
                    end
                end
            end

            if (item_valid && item_ready)
            begin
                case (item.command)
                    slm_pkg::CMD_LOAD_LEFT:
                    begin
                        if (left_fill < DEPTH)
                        begin
                            left_list[left_fill] = item.value;
                            left_fill++;
                        end
                    end
                    slm_pkg::CMD_LOAD_RIGHT:
                    begin
                        if (right_fill < DEPTH)
                        begin
                            right_list[right_fill] = item.value;
                            right_fill++;
                        end
                    end
                    slm_pkg::CMD_MERGE:
                    begin
                        total = left_fill + right_fill;
                        lp = 0;
                        rp = 0;
                        for (int k = 0; k < total; k++)
                        begin
                            // Ties go to the left head, so the merge is stable.
                            take_left = (rp >= right_fill) ||
                                        (lp < left_fill && left_list[lp] <= right_list[rp]);
                            expected.merged_value = take_left ? left_list[lp] : right_list[rp];
                            expected.from_left = take_left;
                            expected.last = (k == total - 1);
                            if (take_left)
                                lp++;
                            else
                                rp++;
                            merged_run_q.push_back(expected);
                        end
                        left_fill = 0;
                        right_fill = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            outstanding <= merged_run_q.size();
        end
    end

endmodule

FILE: dv/sorted_list_merge_tb.sv
// Testbench top for the sorted list merge block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module sorted_list_merge_tb;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 3000;
    localparam int         HOLD_CYCLES = 200;
    localparam int         ITEM_TARGET = 200;

    typedef enum int {SHAPE_SORTED, SHAPE_TIES, SHAPE_SCRAMBLED} run_shape_t;
    typedef logic signed [15:0] elem_q_t [$];

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    slm_pkg::in_item_t  item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    slm_pkg::out_item_t result;
    int                 error_count;
    int                 outstanding;
    int                 idle_pct = 23;
    int                 hold_requests = 0;
    int                 items_sent = 0;

    sorted_list_merge u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    sorted_list_merge_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] val);
        slm_pkg::in_item_t payload;
        payload.command = cmd;
        payload.value = val;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= payload;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic elem_q_t make_run(input int n, input run_shape_t shape);
        elem_q_t vals;
        int      cur;
        int      max_step;
        if (shape == SHAPE_TIES)
        begin
            cur = $urandom_range(0, 8) - 4;
            max_step = 2;
        end
        else
        begin
            cur = $urandom_range(0, 65535) - 32768;
            max_step = $urandom_range(1, 3000);
        end
        for (int k = 0; k < n; k++)
        begin
            if (shape == SHAPE_SCRAMBLED)
                cur = $urandom_range(0, 65535) - 32768;
            else if (k > 0)
                cur = cur + $urandom_range(0, max_step);
            if (cur > 32767)
                cur = 32767;
            vals.push_back(cur[15:0]);
        end
        return vals;
    endfunction

    task automatic run_batch(input int n_left, input int n_right, input run_shape_t shape);
        elem_q_t lvals;
        elem_q_t rvals;
        lvals = make_run(n_left, shape);
        rvals = make_run(n_right, shape);
        while (lvals.size() + rvals.size() > 0)
        begin
            if ($urandom_range(99) < 4)
                send_item(CMD_UNUSED, 16'($urandom_range(0, 65535)));
            if (rvals.size() == 0 || (lvals.size() > 0 && $urandom_range(1) == 1))
                send_item(slm_pkg::CMD_LOAD_LEFT, lvals.pop_front());
            else
                send_item(slm_pkg::CMD_LOAD_RIGHT, rvals.pop_front());
        end
        send_item(slm_pkg::CMD_MERGE, 16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int pick;
        int batch_no;
        batch_no = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty merge and an unused command must both be silent.
        send_item(slm_pkg::CMD_MERGE, 16'h0000);
        send_item(CMD_UNUSED, 16'hFFFF);
        // Extremes on both sides, with ties that must resolve to the left list.
        send_item(slm_pkg::CMD_LOAD_LEFT, 16'h8000);
        send_item(slm_pkg::CMD_LOAD_LEFT, 16'h0000);
        send_item(slm_pkg::CMD_LOAD_RIGHT, 16'h8000);
        send_item(slm_pkg::CMD_LOAD_LEFT, 16'h0005);
        send_item(slm_pkg::CMD_LOAD_RIGHT, 16'h0005);
        send_item(slm_pkg::CMD_LOAD_LEFT, 16'h7FFF);
        send_item(slm_pkg::CMD_LOAD_RIGHT, 16'h7FFF);
        send_item(slm_pkg::CMD_MERGE, 16'h1234);
        // Only the right list holds values, and they are out of order.
        send_item(slm_pkg::CMD_LOAD_RIGHT, 16'd100);
        send_item(slm_pkg::CMD_LOAD_RIGHT, 16'd200);
        send_item(slm_pkg::CMD_LOAD_RIGHT, -16'sd300);
        send_item(slm_pkg::CMD_MERGE, 16'h0000);
        send_item(slm_pkg::CMD_LOAD_LEFT, 16'd42);
        send_item(slm_pkg::CMD_MERGE, 16'hFFFF);
        send_item(slm_pkg::CMD_LOAD_LEFT, 16'd10);
        send_item(slm_pkg::CMD_LOAD_LEFT, -16'sd3);
        send_item(CMD_UNUSED, 16'h5A5A);
        send_item(slm_pkg::CMD_LOAD_RIGHT, 16'h0000);
        send_item(slm_pkg::CMD_MERGE, 16'h0000);
        drain();

        // Both lists overfilled, read out while the receiver holds off.
        hold_requests <= hold_requests + 1;
        run_batch(33, 33, SHAPE_SORTED);
        run_batch(3, 2, SHAPE_TIES);
        drain();

        while (items_sent < ITEM_TARGET)
        begin
            if (batch_no == 6)
                idle_pct <= 0;
            if (batch_no == 16)
                idle_pct <= 23;
            pick = $urandom_range(99);
            if (pick < 55)
                run_batch($urandom_range(0, 6), $urandom_range(0, 6), SHAPE_SORTED);
            else if (pick < 70)
                run_batch($urandom_range(0, 6), $urandom_range(0, 6), SHAPE_TIES);
            else if (pick < 80)
                run_batch($urandom_range(0, 6), $urandom_range(0, 6), SHAPE_SCRAMBLED);
            else if (pick < 86)
                run_batch($urandom_range(24, 34), $urandom_range(24, 34), SHAPE_SORTED);
            else
            begin
                repeat ($urandom_range(0, 4))
                    send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
                send_item(slm_pkg::CMD_MERGE, 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(9) == 0)
                drain();
            batch_no++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
